// ===== hw/rtl/srb_pkg.sv =====
// Package for the slice reorder buffer: sizes, item codes, the entry,
// result and chain-control types and the sequencer states. No dependencies.
package srb_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int MB_W          = 16;
    localparam int EXP_W         = MB_W + 1;
    localparam int FRAME_W       = 8;
    localparam int TAG_W         = 8;

    // input item command codes
    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_SLICE = 1'b1
    } t_cmd;

    // one pending slice
    typedef struct packed {
        logic [MB_W-1:0]    start_mb;
        logic [MB_W-1:0]    end_mb;
        logic [FRAME_W-1:0] frame_index;
        logic [TAG_W-1:0]   payload_tag;
    } t_entry;

    // one result item
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame_index;
        logic               dropped;
    } t_result;

    // control from the sequencer to the row of cells
    typedef struct packed {
        logic   clear;
        logic   ins;
        logic   pop;
        t_entry entry;
    } t_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_RELEASE
    } t_state;

endpackage

// ===== hw/rtl/srb_cell.sv =====
// One cell of the sorted pending row: holds one entry and its valid bit.
// Depends on srb_pkg.
module srb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srb_pkg::t_ctrl i_ctrl,
    input  logic           i_prev_valid,
    input  logic           i_prev_after,
    input  logic           i_next_valid,
    input  srb_pkg::t_entry i_next_entry,
    output logic           o_valid,
    output logic           o_after,
    output srb_pkg::t_entry o_entry
);
    import srb_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   ins_here;
    logic   shift_here;

    // new entry sorts after this one (equal keys stay ahead of the new one)
    assign o_after    = r_valid && (r_entry.start_mb <= i_ctrl.entry.start_mb);
    assign ins_here   = i_prev_after && !o_after;
    assign shift_here = i_prev_valid && !i_prev_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_valid <= i_next_valid;
        end else if (i_ctrl.ins && (ins_here || shift_here)) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_entry <= i_next_entry;
        end else if (i_ctrl.ins && ins_here) begin
            r_entry <= i_ctrl.entry;
        end else if (i_ctrl.ins && shift_here) begin
            // take the left neighbor's entry to open the slot
            r_entry <= i_next_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

// ===== hw/rtl/srb_chain.sv =====
// Row of pending cells kept sorted by first macroblock; head is cell 0.
// Depends on srb_pkg and srb_cell.
module srb_chain (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srb_pkg::t_ctrl  i_ctrl,
    output logic            o_head_valid,
    output srb_pkg::t_entry o_head,
    output logic            o_full
);
    import srb_pkg::*;

    logic   valid [PENDING_DEPTH];
    logic   after [PENDING_DEPTH];
    t_entry entry [PENDING_DEPTH];
    t_entry shift_src [PENDING_DEPTH];

    genvar g;
    generate
        for (g = 0; g < PENDING_DEPTH; g++) begin : g_cell
            logic   prev_valid;
            logic   prev_after;
            logic   next_valid;
            t_entry next_entry;
            t_entry cell_in;

            if (g == 0) begin : g_head
                assign prev_valid = 1'b0;
                assign prev_after = 1'b1;
                assign shift_src[g] = '0;
            end else begin : g_body
                assign prev_valid = valid[g-1];
                assign prev_after = after[g-1];
                assign shift_src[g] = entry[g-1];
            end

            if (g == PENDING_DEPTH - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_entry = '0;
            end else begin : g_mid
                assign next_valid = valid[g+1];
                assign next_entry = entry[g+1];
            end

            // pop takes the right neighbor; an insert shift takes the left one
            assign cell_in = i_ctrl.pop ? next_entry : shift_src[g];

            srb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_prev_valid (prev_valid),
                .i_prev_after (prev_after),
                .i_next_valid (next_valid),
                .i_next_entry (cell_in),
                .o_valid      (valid[g]),
                .o_after      (after[g]),
                .o_entry      (entry[g])
            );
        end
    endgenerate

    assign o_head_valid = valid[0];
    assign o_head       = entry[0];
    assign o_full       = valid[PENDING_DEPTH-1];

endmodule

// ===== hw/rtl/slice_reorder_buffer_top.sv =====
// Top level of the slice reorder buffer: sequencer, held result, output
// register and the row of pending cells. Depends on srb_pkg and srb_chain.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_stall | i_command, i_start_mb, i_end_mb,
//          |         |         | i_frame_index, i_payload_tag
//  output  | o_valid | i_stall | o_out_tag, o_out_frame_index, o_dropped,
//          |         |         | o_last_of_run
//
// A start-of-frame item is taken in the idle state. A slice item is accepted
// there (match, drop or sorted insert into the cell row); the release state
// then gives out its results, walking the head cell of the row while it
// matches the expected macroblock, and is entered even when nothing is
// released.
// One item is worked on at a time; o_stall is high for the whole run.
// Output stalls hold the run; the last result may still wait in the output
// register while the next item is accepted.
// Reset (synchronous, active low) empties the row and sets the expected
// macroblock to zero; no clearing pass is needed.
module slice_reorder_buffer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [srb_pkg::MB_W-1:0]      i_start_mb,
    input  logic [srb_pkg::MB_W-1:0]      i_end_mb,
    input  logic [srb_pkg::FRAME_W-1:0]   i_frame_index,
    input  logic [srb_pkg::TAG_W-1:0]     i_payload_tag,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [srb_pkg::TAG_W-1:0]     o_out_tag,
    output logic [srb_pkg::FRAME_W-1:0]   o_out_frame_index,
    output logic                          o_dropped,
    output logic                          o_last_of_run
);
    import srb_pkg::*;

    // sequencer state
    t_state            r_state,       n_state;
    logic [EXP_W-1:0]  r_expected_mb, n_expected_mb;
    // result held until we know whether another one follows it
    logic              r_hold_valid,  n_hold_valid;
    t_result           r_hold,        n_hold;
    // output register
    logic              r_out_valid,   n_out_valid;
    t_result           r_out,         n_out;
    logic              r_out_last,    n_out_last;

    t_ctrl             chain_ctrl;
    logic              head_valid;
    t_entry            head;
    logic              full;

    logic              in_acc;
    logic              out_free;
    logic              head_match;
    logic              slice_match;
    logic              load_out;

    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign head_match  = head_valid && ({1'b0, head.start_mb} == r_expected_mb);
    assign slice_match = ({1'b0, i_start_mb} == r_expected_mb);

    // pending row
    srb_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (chain_ctrl),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_full       (full)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_command == CMD_SLICE)) begin
                    n_state = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                // leave once the head no longer matches and nothing is held back
                if (!head_match && (!r_hold_valid || out_free)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and row control
    always_comb begin
        n_expected_mb    = r_expected_mb;
        n_hold_valid     = r_hold_valid;
        n_hold           = r_hold;
        load_out         = 1'b0;
        n_out            = r_out;
        n_out_last       = r_out_last;
        chain_ctrl.clear = 1'b0;
        chain_ctrl.ins   = 1'b0;
        chain_ctrl.pop   = 1'b0;
        chain_ctrl.entry = '{start_mb: i_start_mb, end_mb: i_end_mb,
                             frame_index: i_frame_index, payload_tag: i_payload_tag};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_FRAME) begin
                        // drop everything pending, expect macroblock zero
                        chain_ctrl.clear = 1'b1;
                        n_expected_mb    = '0;
                    end else if (slice_match) begin
                        n_hold_valid  = 1'b1;
                        n_hold        = '{tag: i_payload_tag, frame_index: i_frame_index,
                                          dropped: 1'b0};
                        n_expected_mb = {1'b0, i_end_mb} + EXP_W'(1);
                    end else if (full) begin
                        n_hold_valid = 1'b1;
                        n_hold       = '{tag: i_payload_tag, frame_index: i_frame_index,
                                         dropped: 1'b1};
                    end else begin
                        chain_ctrl.ins = 1'b1;
                        n_hold_valid   = 1'b0;
                    end
                end
            end
            ST_RELEASE: begin
                if (r_hold_valid && out_free) begin
                    // release the held result; it ends the run unless the head matches
                    load_out     = 1'b1;
                    n_out        = r_hold;
                    n_out_last   = !head_match;
                    n_hold_valid = 1'b0;
                end
                if (head_match && (!r_hold_valid || out_free)) begin
                    // advance past the head entry
                    chain_ctrl.pop = 1'b1;
                    n_hold_valid   = 1'b1;
                    n_hold         = '{tag: head.payload_tag, frame_index: head.frame_index,
                                       dropped: 1'b0};
                    n_expected_mb  = {1'b0, head.end_mb} + EXP_W'(1);
                end
            end
            default: ;
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_expected_mb <= '0;
            r_hold_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_expected_mb <= n_expected_mb;
            r_hold_valid  <= n_hold_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (load_out) begin
            r_out      <= n_out;
            r_out_last <= n_out_last;
        end
    end

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_out_valid;
    assign o_out_tag         = r_out.tag;
    assign o_out_frame_index = r_out.frame_index;
    assign o_dropped         = r_out.dropped;
    assign o_last_of_run     = r_out_last;

    // a pop never runs on an empty row, an insert never on a full one
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_ctrl.pop |-> head_valid)
        else $error("pop on empty pending row");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_ctrl.ins |-> !full)
        else $error("insert into full pending row");

    // start of frame leaves the row empty
    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_FRAME)) |=> !head_valid)
        else $error("row not empty after start of frame");

    // nothing is left held back once the run is over
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("result held while idle");

endmodule
